// ----- rtl/core/hte_pkg.sv -----
// Shared types, constants and tables for the homogeneous transform engine.
// No dependencies; the RTL files use this package by scoped names, the testbench imports it.
package hte_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);
    localparam int ANG_W        = 16;
    localparam int DATA_W       = 32;
    localparam int CRD_W        = 34;
    localparam int ACC_W        = 66;

    localparam logic [2:0] OP_IDENT = 3'd0;
    localparam logic [2:0] OP_ROLL  = 3'd1;
    localparam logic [2:0] OP_PITCH = 3'd2;
    localparam logic [2:0] OP_YAW   = 3'd3;
    localparam logic [2:0] OP_TRANS = 3'd4;
    localparam logic [2:0] OP_POINT = 3'd5;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    localparam logic signed [CRD_W-1:0] GAIN_Q30    = 34'sd652032875;
    localparam logic signed [CRD_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CRD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [ANG_W-1:0] angle;
        data_t                   cx;
        data_t                   cy;
        data_t                   cz;
    } cmd_t;

    function automatic logic signed [CRD_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic signed [CRD_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sh03243F6A8;
            5'd1:    v = 34'sh01DAC6705;
            5'd2:    v = 34'sh00FADBAFC;
            5'd3:    v = 34'sh007F56EA6;
            5'd4:    v = 34'sh003FEAB76;
            5'd5:    v = 34'sh001FFD55B;
            5'd6:    v = 34'sh000FFFAAA;
            5'd7:    v = 34'sh0007FFF55;
            5'd8:    v = 34'sh0003FFFEA;
            5'd9:    v = 34'sh0001FFFFD;
            5'd10:   v = 34'sh0000FFFFF;
            5'd11:   v = 34'sh00007FFFF;
            5'd12:   v = 34'sh00003FFFF;
            5'd13:   v = 34'sh00001FFFF;
            5'd14:   v = 34'sh00000FFFF;
            5'd15:   v = 34'sh000007FFF;
            5'd16:   v = 34'sh000003FFF;
            5'd17:   v = 34'sh000001FFF;
            5'd18:   v = 34'sh000000FFF;
            5'd19:   v = 34'sh0000007FF;
            5'd20:   v = 34'sh0000003FF;
            5'd21:   v = 34'sh0000001FF;
            5'd22:   v = 34'sh0000000FF;
            5'd23:   v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/hte_front.sv -----
// Front end: accepts input transactions, drops unused opcodes and queues commands.
// Depends on hte_pkg.
module hte_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [111:0]        s_tdata,   // angle, coord_x, coord_y, coord_z
    input  logic [2:0]          s_tuser,   // opcode
    output logic                q_valid,
    output hte_pkg::cmd_t       q_cmd,
    input  logic                q_pop,
    output logic                q_full
);

    hte_pkg::cmd_t q_reg [2];
    logic          wr_reg, wr_next;
    logic          rd_reg, rd_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    hte_pkg::cmd_t in_cmd;

    assign in_cmd.op    = s_tuser;
    assign in_cmd.angle = $signed(s_tdata[15:0]);
    assign in_cmd.cx    = $signed(s_tdata[47:16]);
    assign in_cmd.cy    = $signed(s_tdata[79:48]);
    assign in_cmd.cz    = $signed(s_tdata[111:80]);

    assign q_full   = (cnt_reg == 2'd2);
    assign s_tready = !q_full;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rd_reg];
    assign push     = s_tvalid && s_tready && (s_tuser <= hte_pkg::OP_POINT);

    always_comb begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = q_pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/core/hte_cordic.sv -----
// Iterative rotation-mode CORDIC giving sine and cosine, one step per cycle.
// Depends on hte_pkg.
module hte_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [15:0]  angle,
    output logic                done,
    output hte_pkg::data_t      sin_out,
    output hte_pkg::data_t      cos_out
);

    localparam int SH = 30 - hte_pkg::FRAC_BITS;
    localparam logic signed [hte_pkg::CRD_W-1:0] HALF = hte_pkg::CRD_W'(1) << (SH - 1);

    logic                              busy_reg, busy_next;
    logic [hte_pkg::STEP_W-1:0]        cnt_reg, cnt_next;
    logic                              flip_reg;
    logic signed [hte_pkg::CRD_W-1:0]  x_reg, y_reg, z_reg;
    logic signed [hte_pkg::CRD_W-1:0]  z0, z_adj, xs, ys, x_step, y_step, z_step;
    logic signed [hte_pkg::CRD_W-1:0]  xr, yr;
    logic                              flip0, last;

    always_comb begin
        z0    = hte_pkg::CRD_W'($signed({angle, 17'b0}));
        flip0 = 1'b1;
        priority if (z0 > hte_pkg::HALF_PI_Q30) begin
            z_adj = z0 - hte_pkg::PI_Q30;
        end else if (z0 < -hte_pkg::HALF_PI_Q30) begin
            z_adj = z0 + hte_pkg::PI_Q30;
        end else begin
            z_adj = z0;
            flip0 = 1'b0;
        end
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        if (!z_reg[hte_pkg::CRD_W-1]) begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - hte_pkg::atan_q30(cnt_reg);
        end else begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + hte_pkg::atan_q30(cnt_reg);
        end
        last      = (cnt_reg == hte_pkg::STEP_W'(hte_pkg::CORDIC_ITERS - 1));
        busy_next = start ? 1'b1 : (busy_reg && !last);
        cnt_next  = start ? '0 : cnt_reg + 1'b1;
        xr        = (x_reg + HALF) >>> SH;
        yr        = (y_reg + HALF) >>> SH;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done     <= busy_reg && last;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (start) begin
            x_reg    <= hte_pkg::GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= z_adj;
            flip_reg <= flip0;
        end else if (busy_reg) begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
    end

    assign cos_out = flip_reg ? -xr[31:0] : xr[31:0];
    assign sin_out = flip_reg ? -yr[31:0] : yr[31:0];

endmodule

// ----- rtl/core/hte_back.sv -----
// Back end: holds the pose matrix, runs rotations, translations and point transforms
// on one shared multiplier-accumulator, and drives the result register. Depends on
// hte_pkg and hte_cordic.
module hte_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  hte_pkg::cmd_t       q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [95:0]         m_tdata    // out_x, out_y, out_z
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CORD  = 2'd1;
    localparam logic [1:0] ST_MAC   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    localparam logic signed [hte_pkg::ACC_W-1:0] ACC_HALF =
        hte_pkg::ACC_W'(1) << (hte_pkg::FRAC_BITS - 1);
    localparam logic signed [hte_pkg::ACC_W-1:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [hte_pkg::ACC_W-1:0] SAT_LO = -66'sd2147483648;

    logic [1:0]           state_reg, state_next;
    hte_pkg::cmd_t        cmd_reg;
    hte_pkg::data_t       sin_reg, cos_reg, sin_w, cos_w;
    hte_pkg::data_t       mat_reg [12];
    hte_pkg::data_t       row_reg [3];
    hte_pkg::data_t       res_x_reg, res_y_reg;
    logic [1:0]           i_reg, j_reg, k_reg, i_next, j_next, k_next;
    logic                 cord_start, cord_done;
    logic                 is_point, issue, issue_last;
    hte_pkg::data_t       a_op, b_op;

    logic signed [63:0]   prod_reg;
    logic                 p_vld_reg, p_first_reg, p_last_reg, p_fin_reg;
    logic [1:0]           p_i_reg, p_j_reg;
    logic signed [hte_pkg::ACC_W-1:0] acc_reg, acc_next, rnd;
    logic                 r_vld_reg, r_fin_reg;
    logic [1:0]           r_i_reg, r_j_reg;
    hte_pkg::data_t       res;
    logic                 m_vld_reg;
    logic [95:0]          m_data_reg;
    logic                 start_ok;

    function automatic hte_pkg::data_t b_elem(input hte_pkg::cmd_t c, input hte_pkg::data_t s,
                                              input hte_pkg::data_t co, input logic [1:0] k,
                                              input logic [1:0] j);
        hte_pkg::data_t v;
        v = (k == j) ? hte_pkg::ONE : '0;
        if (c.op == hte_pkg::OP_POINT) begin
            unique case (k)
                2'd0: v = c.cx;
                2'd1: v = c.cy;
                2'd2: v = c.cz;
                2'd3: v = hte_pkg::ONE;
            endcase
        end else if (k != 2'd3) begin
            if (c.op == hte_pkg::OP_ROLL) begin
                if ((k == 2'd1 && j == 2'd1) || (k == 2'd2 && j == 2'd2)) v = co;
                if (k == 2'd1 && j == 2'd2) v = -s;
                if (k == 2'd2 && j == 2'd1) v = s;
            end else if (c.op == hte_pkg::OP_PITCH) begin
                if ((k == 2'd0 && j == 2'd0) || (k == 2'd2 && j == 2'd2)) v = co;
                if (k == 2'd0 && j == 2'd2) v = s;
                if (k == 2'd2 && j == 2'd0) v = -s;
            end else if (c.op == hte_pkg::OP_YAW) begin
                if ((k == 2'd0 && j == 2'd0) || (k == 2'd1 && j == 2'd1)) v = co;
                if (k == 2'd0 && j == 2'd1) v = -s;
                if (k == 2'd1 && j == 2'd0) v = s;
            end else if (c.op == hte_pkg::OP_TRANS && j == 2'd3) begin
                unique case (k)
                    2'd0: v = c.cx;
                    2'd1: v = c.cy;
                    default: v = c.cz;
                endcase
            end
        end
        return v;
    endfunction

    hte_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .angle   (q_cmd.angle),
        .done    (cord_done),
        .sin_out (sin_w),
        .cos_out (cos_w)
    );

    always_comb begin
        start_ok   = q_valid && (q_cmd.op != hte_pkg::OP_POINT || !m_vld_reg);
        q_pop      = (state_reg == ST_IDLE) && start_ok;
        cord_start = q_pop && (q_cmd.op == hte_pkg::OP_ROLL || q_cmd.op == hte_pkg::OP_PITCH
                               || q_cmd.op == hte_pkg::OP_YAW);
        is_point   = (cmd_reg.op == hte_pkg::OP_POINT);
        issue      = (state_reg == ST_MAC);
        issue_last = (k_reg == 2'd3) && (i_reg == 2'd2) && (is_point || j_reg == 2'd3);
        a_op       = mat_reg[{i_reg, k_reg}];
        b_op       = b_elem(cmd_reg, sin_reg, cos_reg, k_reg, j_reg);

        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg + 2'd1;
        if (k_reg == 2'd3) begin
            if (is_point || j_reg == 2'd3) begin
                j_next = 2'd0;
                i_next = i_reg + 2'd1;
            end else begin
                j_next = j_reg + 2'd1;
            end
        end

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    priority if (cord_start) state_next = ST_CORD;
                    else if (q_cmd.op == hte_pkg::OP_IDENT) state_next = ST_IDLE;
                    else state_next = ST_MAC;
                end
            end
            ST_CORD:  if (cord_done) state_next = ST_MAC;
            ST_MAC:   if (issue_last) state_next = ST_DRAIN;
            ST_DRAIN: if (r_vld_reg && r_fin_reg) state_next = ST_IDLE;
        endcase

        acc_next = (p_first_reg ? '0 : acc_reg) + hte_pkg::ACC_W'(prod_reg);
        rnd      = (acc_reg + ACC_HALF) >>> hte_pkg::FRAC_BITS;
        priority if (rnd > SAT_HI) res = 32'sh7FFFFFFF;
        else if (rnd < SAT_LO) res = 32'sh80000000;
        else res = rnd[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            p_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            for (int n = 0; n < 12; n++) begin
                mat_reg[n] <= (n % 5 == 0) ? hte_pkg::ONE : '0;
            end
        end else begin
            state_reg <= state_next;
            p_vld_reg <= issue;
            r_vld_reg <= p_vld_reg && p_last_reg;
            if (m_vld_reg && m_tready) m_vld_reg <= 1'b0;
            if (r_vld_reg && r_fin_reg && is_point) m_vld_reg <= 1'b1;
            if (q_pop && q_cmd.op == hte_pkg::OP_IDENT) begin
                for (int n = 0; n < 12; n++) begin
                    mat_reg[n] <= (n % 5 == 0) ? hte_pkg::ONE : '0;
                end
            end else if (r_vld_reg && !is_point && r_j_reg == 2'd3) begin
                mat_reg[{r_i_reg, 2'd0}] <= row_reg[0];
                mat_reg[{r_i_reg, 2'd1}] <= row_reg[1];
                mat_reg[{r_i_reg, 2'd2}] <= row_reg[2];
                mat_reg[{r_i_reg, 2'd3}] <= res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) cmd_reg <= q_cmd;
        if (cord_done) begin
            sin_reg <= sin_w;
            cos_reg <= cos_w;
        end
        if (state_reg != ST_MAC) begin
            i_reg <= 2'd0;
            j_reg <= 2'd0;
            k_reg <= 2'd0;
        end else begin
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
        end
        prod_reg    <= a_op * b_op;
        p_first_reg <= (k_reg == 2'd0);
        p_last_reg  <= (k_reg == 2'd3);
        p_fin_reg   <= issue_last;
        p_i_reg     <= i_reg;
        p_j_reg     <= j_reg;
        if (p_vld_reg) acc_reg <= acc_next;
        r_fin_reg <= p_fin_reg;
        r_i_reg   <= p_i_reg;
        r_j_reg   <= p_j_reg;
        if (r_vld_reg) begin
            if (is_point) begin
                if (r_i_reg == 2'd0) res_x_reg <= res;
                if (r_i_reg == 2'd1) res_y_reg <= res;
                if (r_fin_reg) m_data_reg <= {res, res_y_reg, res_x_reg};
            end else if (r_j_reg != 2'd3) begin
                row_reg[r_j_reg] <= res;
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/core/homogeneous_transform_engine.sv -----
// Homogeneous transform engine: pose matrix update and point transform.
// A command queue (front) feeds a CORDIC and single-multiplier sequencer (back). An
// identity command only resets the pose when it is dispatched; a translation takes a
// dispatch step, 48 multiply-accumulate steps on the one shared 32x32 multiplier and
// the pipeline drain, a rotation the CORDIC sine/cosine iterations before those, and a
// point transform 12 steps. The front queue holds two commands, so input transactions
// are taken while the back end works or a result waits; opcodes 6 and 7 are dropped.
// Depends on hte_pkg, hte_front, hte_back and hte_cordic.
module homogeneous_transform_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,   // angle, coord_x, coord_y, coord_z
    input  logic [2:0]    s_tuser,   // opcode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata    // out_x, out_y, out_z
);

    logic          q_valid, q_pop, q_full;
    hte_pkg::cmd_t q_cmd;

    hte_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .q_full   (q_full)
    );

    hte_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_reset_no_result: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_point_needs_free_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.op == hte_pkg::OP_POINT) |-> !m_tvalid)
        else $error("point transform started while result register busy");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready)
        else $error("input taken with command queue full");

endmodule

// ----- bench/tb_homogeneous_transform_engine.sv -----
// Testbench for homogeneous_transform_engine: a directed table, then random pose updates,
// point transforms and unused opcodes; points are checked against table values or a behavioural pose predictor.
// Depends on hte_pkg and the engine RTL.
module tb_homogeneous_transform_engine;
    import hte_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 400;
    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam longint GAIN = 64'sd652032875;
    localparam longint PI_FX = 64'sd3373259426;
    localparam longint HALF_PI_FX = 64'sd1686629713;

    typedef struct {
        logic signed [31:0] x, y, z;
    } point_t;

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] ang;
        logic signed [31:0] cx, cy, cz;
        bit                 typed;
        point_t             want;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;   // angle, coord_x, coord_y, coord_z
    logic [2:0]   s_tuser = '0;   // opcode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;        // out_x, out_y, out_z

    longint pose[12];
    point_t pending_points[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     gaps_on = 1'b1;
    bit     hold_req = 1'b0;

    homogeneous_transform_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_dot(longint a[4], longint b[4]);
        longint whole, frac, p;
        whole = 0;
        frac = 0;
        for (int k = 0; k < 4; k++) begin
            p = a[k] * b[k];
            whole += p >>> FRAC_BITS;
            frac += p & (UNIT - 1);
        end
        return clamp32(whole + ((frac + (UNIT >>> 1)) >>> FRAC_BITS));
    endfunction

    function automatic longint arctan_step(int i);
        return longint'($signed(atan_q30(i[STEP_W-1:0])));
    endfunction

    function automatic void sin_cos(longint ang, output longint s, output longint c);
        longint z, x, y, t, half;
        bit flip;
        int sh;
        z = ang * 131072;
        x = GAIN;
        y = 0;
        flip = 1'b0;
        sh = 30 - FRAC_BITS;
        half = longint'(1) << (sh - 1);
        if (z > HALF_PI_FX) begin
            z -= PI_FX;
            flip = 1'b1;
        end else if (z < -HALF_PI_FX) begin
            z += PI_FX;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_step(i);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_step(i);
            end
            x = t;
        end
        x = (x + half) >>> sh;
        y = (y + half) >>> sh;
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic void pose_identity();
        for (int i = 0; i < 12; i++) pose[i] = (i % 5 == 0) ? UNIT : 0;
    endfunction

    function automatic void pose_mul(longint b[3][4]);
        longint nxt[12];
        longint a[4], col[4];
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 4; k++) a[k] = pose[i*4+k];
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) col[k] = b[k][j];
                col[3] = (j == 3) ? UNIT : 0;
                nxt[i*4+j] = fx_dot(a, col);
            end
        end
        pose = nxt;
    endfunction

    function automatic bit pose_step(logic [2:0] op, logic signed [15:0] ang,
                                     logic signed [31:0] cx, logic signed [31:0] cy,
                                     logic signed [31:0] cz, output point_t r);
        longint b[3][4];
        longint a[4], p[4];
        longint s, c;
        r = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++) b[i][j] = (i == j) ? UNIT : 0;
        case (op)
            OP_IDENT: pose_identity();
            OP_ROLL, OP_PITCH, OP_YAW: begin
                sin_cos(longint'(ang), s, c);
                if (op == OP_ROLL) begin
                    b[1][1] = c; b[1][2] = -s; b[2][1] = s; b[2][2] = c;
                end else if (op == OP_PITCH) begin
                    b[0][0] = c; b[0][2] = s; b[2][0] = -s; b[2][2] = c;
                end else begin
                    b[0][0] = c; b[0][1] = -s; b[1][0] = s; b[1][1] = c;
                end
                pose_mul(b);
            end
            OP_TRANS: begin
                b[0][3] = cx; b[1][3] = cy; b[2][3] = cz;
                pose_mul(b);
            end
            OP_POINT: begin
                p[0] = cx; p[1] = cy; p[2] = cz; p[3] = UNIT;
                for (int k = 0; k < 4; k++) a[k] = pose[k];
                r.x = fx_dot(a, p);
                for (int k = 0; k < 4; k++) a[k] = pose[4+k];
                r.y = fx_dot(a, p);
                for (int k = 0; k < 4; k++) a[k] = pose[8+k];
                r.z = fx_dot(a, p);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send(row_t r);
        int gap;
        point_t res;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {r.cz, r.cy, r.cx, r.ang};
        do @(posedge aclk); while (!s_tready);
        if (pose_step(r.op, r.ang, r.cx, r.cy, r.cz, res))
            pending_points.push_back(r.typed ? r.want : res);
    endtask

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $signed($urandom_range(0, 2**21)) - 2**20;
    endfunction

    function automatic row_t rand_row();
        row_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.op = (pick < 5)  ? OP_IDENT :
               (pick < 15) ? OP_ROLL  :
               (pick < 25) ? OP_PITCH :
               (pick < 35) ? OP_YAW   :
               (pick < 55) ? OP_TRANS :
               (pick < 95) ? OP_POINT :
               (pick < 97) ? OP_SPARE_A : OP_SPARE_B;
        r.ang = $signed($urandom_range(0, 51472)) - 25736;
        r.cx = rand_coord();
        r.cy = rand_coord();
        r.cz = rand_coord();
        r.typed = 1'b0;
        r.want = '{0, 0, 0};
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                errors++;
                $display("unexpected result transaction %h at %0t", m_tdata, $realtime);
            end else begin
                point_t w;
                w = pending_points.pop_front();
                if ($signed(m_tdata[31:0]) !== w.x) report_mismatch("out_x", m_tdata[31:0], w.x);
                if ($signed(m_tdata[63:32]) !== w.y) report_mismatch("out_y", m_tdata[63:32], w.y);
                if ($signed(m_tdata[95:64]) !== w.z) report_mismatch("out_z", m_tdata[95:64], w.z);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = gaps_on ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        row_t table_rows[$];
        row_t r;
        pose_identity();
        table_rows = '{
            '{OP_POINT, 16'sd0, 32'sd65536, 32'sd131072, -32'sd196608, 1, '{65536, 131072, -196608}},
            '{OP_POINT, 16'sd0, 32'h7fffffff, 32'h80000000, 32'sd0, 1,
              '{32'h7fffffff, 32'h80000000, 0}},
            '{OP_TRANS, 16'sd0, 32'h7fffffff, 32'h80000000, 32'sd65536, 0, '{0, 0, 0}},
            '{OP_POINT, 16'sd0, 32'h7fffffff, 32'h80000000, 32'sd65536, 1,
              '{32'h7fffffff, 32'h80000000, 131072}},
            '{OP_SPARE_A, 16'sd0, 32'sd1, 32'sd2, 32'sd3, 0, '{0, 0, 0}},
            '{OP_SPARE_B, 16'sd25736, 32'sd1, 32'sd2, 32'sd3, 0, '{0, 0, 0}},
            '{OP_IDENT, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_POINT, 16'sd0, -32'sd1, 32'sd1, 32'sd0, 1, '{-1, 1, 0}},
            '{OP_ROLL, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_ROLL, 16'sd12868, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_POINT, 16'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 0, '{0, 0, 0}},
            '{OP_PITCH, 16'sd12869, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_YAW, -16'sd12869, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_POINT, 16'sd0, 32'sd65536, -32'sd65536, 32'sd327680, 0, '{0, 0, 0}},
            '{OP_ROLL, 16'sd25736, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_PITCH, -16'sd25736, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_YAW, 16'sh7fff, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_YAW, 16'sh8000, 32'sd0, 32'sd0, 32'sd0, 0, '{0, 0, 0}},
            '{OP_TRANS, 16'sd0, -32'sd98304, 32'sd40000, 32'sd7, 0, '{0, 0, 0}},
            '{OP_POINT, 16'sd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, '{0, 0, 0}},
            '{OP_POINT, 16'sd0, 32'sd123456, -32'sd654321, 32'sd1, 0, '{0, 0, 0}}
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (table_rows[i]) send(table_rows[i]);
        for (int n = 0; n < 1400; n++) begin
            if (n % 200 == 0) gaps_on = $urandom_range(0, 3) != 0;
            if (n == 700) begin
                hold_req = 1'b1;
                gaps_on = 1'b0;
                r.op = OP_POINT;
                for (int k = 0; k < 30; k++) begin
                    r = rand_row();
                    r.op = OP_POINT;
                    send(r);
                end
            end
            send(rand_row());
        end
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
